@@ design/icfe_pkg.sv @@
`default_nettype none

package icfe_pkg;

  localparam int MAX_SIDE_DEF    = 64;
  localparam int STACK_DEPTH_DEF = 16384;
  localparam int SIDE_RESET      = 64;
  localparam logic [31:0] THRESH_RESET = 32'd2515933591;

  localparam int RAND_W      = 32;
  localparam int SIDE_CFG_W  = 7;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_ADDR_W  = 1;
  localparam int WORK_W      = 15;
  localparam int MAG_W       = 13;
  localparam int ENERGY_W    = 15;
  localparam int OUT_TDATA_W = 48;
  localparam int WORK_MAX    = 32767;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_SIDE,
    CFG_THRESH
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_ROW,
    PH_COL,
    PH_GROW
  } phase_t;

  typedef enum logic [3:0] {
    ST_WAIT,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_FLIP,
    ST_PUSH,
    ST_POP,
    ST_POP_RD,
    ST_CHK,
    ST_EMIT
  } state_t;

endpackage

`default_nettype wire

@@ design/icfe_row_store.sv @@
`default_nettype none

module icfe_row_store #(
  parameter int ROWS = icfe_pkg::MAX_SIDE_DEF,
  parameter int COLS = icfe_pkg::MAX_SIDE_DEF,
  parameter bit FILL = 1'b0
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     clr,
  input  wire logic [$clog2(ROWS)-1:0]  rd_row,
  output logic      [COLS-1:0]          rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(ROWS)-1:0]  wr_row,
  input  wire logic [COLS-1:0]          wr_data
);

  logic [COLS-1:0] mem [ROWS];
  logic [ROWS-1:0] ok;
  logic [COLS-1:0] q;
  logic            q_ok;

  // rows never written since the last reset or clear read as the fill value
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      ok <= '0;
    end else if (wr_en) begin
      ok[wr_row] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_row] <= wr_data;
    end
    q    <= mem[rd_row];
    q_ok <= ok[rd_row];
  end

  assign rd_data = q_ok ? q : {COLS{FILL}};

endmodule

`default_nettype wire

@@ design/ising_cluster_flip_engine_unit.sv @@
`default_nettype none

// Wolff cluster engine for a periodic square Ising lattice held as rows of
// spin and mark bits in two row-wide memories. Each item is one random draw.
// A seed draw or an accepted bond flips a site: three row reads, one update
// step and four push slots. Every site popped from the stack memory passes a
// pop, a row read and a check, and a finished cluster ends with a step that
// finds the stack empty and one that loads the result register when the
// output is free. The cluster walk therefore sets the rate; a new draw is
// taken only once the walk is back in its waiting state. Writing lattice_side
// restarts the lattice at once through per-row valid bits; no clearing pass is needed.
module ising_cluster_flip_engine_unit #(
  parameter int MAX_SIDE    = icfe_pkg::MAX_SIDE_DEF,
  parameter int STACK_DEPTH = icfe_pkg::STACK_DEPTH_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 s_tvalid,
  output logic                                      s_tready,
  input  wire logic [icfe_pkg::RAND_W-1:0]          s_tdata,   // random_fraction
  output logic                                      m_tvalid,
  input  wire logic                                 m_tready,
  // cluster_work[14:0], magnetization_abs[27:15], total_energy[42:28]
  output logic      [icfe_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  wire logic                                 cfg_we,
  input  wire logic [icfe_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire logic [icfe_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int RW   = $clog2(MAX_SIDE);
  localparam int SW   = $clog2(MAX_SIDE + 1);
  localparam int STW  = 2 * RW;
  localparam int CW   = $clog2(STACK_DEPTH + 1);
  localparam int SAW  = $clog2(STACK_DEPTH);
  localparam int EW_D = $clog2(2 * MAX_SIDE * MAX_SIDE + 1) + 1;
  localparam int MW_D = $clog2(MAX_SIDE * MAX_SIDE + 1) + 1;
  localparam int EW   = EW_D > icfe_pkg::ENERGY_W ? EW_D : icfe_pkg::ENERGY_W;
  localparam int MW   = MW_D > icfe_pkg::MAG_W + 1 ? MW_D : icfe_pkg::MAG_W + 1;
  localparam int SIDE_RST = icfe_pkg::SIDE_RESET > MAX_SIDE ? MAX_SIDE
                                                            : icfe_pkg::SIDE_RESET;
  localparam int PAD_W = icfe_pkg::OUT_TDATA_W - icfe_pkg::WORK_W - icfe_pkg::MAG_W
                         - icfe_pkg::ENERGY_W;

  icfe_pkg::state_t state, state_next;
  icfe_pkg::phase_t phase;

  logic [SW-1:0]                 side;
  logic [31:0]                   thresh;
  logic [RW-1:0]                 seed_row;
  logic                          seed_spin;
  logic [STW-1:0]                held_site;
  logic [RW-1:0]                 cur_row;
  logic [RW-1:0]                 cur_col;
  logic                          is_seed;
  logic [icfe_pkg::WORK_W-1:0]   bond_tries;
  logic signed [MW-1:0]          magnet;
  logic signed [EW-1:0]          energy;
  logic [CW-1:0]                 pend_count;
  logic [1:0]                    push_idx;
  logic [3:0]                    push_mask;
  logic [STW-1:0]                push_site [4];
  logic [MAX_SIDE-1:0]           up_spin, mid_spin, dn_spin;
  logic [MAX_SIDE-1:0]           up_mark, mid_mark, dn_mark;
  logic [STW-1:0]                pop_site;
  logic [STW-1:0]                stack_mem [STACK_DEPTH];
  logic [STW-1:0]                stack_q;

  logic                          in_acc;
  logic [SW+31:0]                pick_prod;
  logic [RW-1:0]                 pick;
  logic                          bond_ok;
  logic [SW-1:0]                 side_m1;
  logic [RW-1:0]                 row_up, row_dn, col_l, col_r;
  logic [RW-1:0]                 rd_row;
  logic                          wr_en;
  logic [MAX_SIDE-1:0]           spin_wr, mark_wr, spin_rd, mark_rd;
  logic                          clr_marks, restart;
  logic                          s_old;
  logic [2:0]                    nb_up_cnt;
  logic signed [5:0]             kk, de;
  logic [CW-1:0]                 pop_addr;
  logic [SAW-1:0]                stack_raddr;
  logic                          push_do;
  logic                          pop_hit;
  logic [MW-1:0]                 mag_abs;
  logic [SW-1:0]                 side_new;
  logic [2*SW-1:0]               side_sq;

  assign in_acc    = s_tvalid && s_tready;
  assign pick_prod = (SW + 32)'(side) * (SW + 32)'(s_tdata);
  assign pick      = pick_prod[RW+31:32];
  assign bond_ok   = s_tdata < thresh;

  assign side_m1 = side - SW'(1);
  assign row_up  = (cur_row == '0) ? side_m1[RW-1:0] : cur_row - RW'(1);
  assign row_dn  = (SW'(cur_row) == side_m1) ? '0 : cur_row + RW'(1);
  assign col_l   = (cur_col == '0) ? side_m1[RW-1:0] : cur_col - RW'(1);
  assign col_r   = (SW'(cur_col) == side_m1) ? '0 : cur_col + RW'(1);

  assign s_old     = mid_spin[cur_col];
  assign nb_up_cnt = 3'(up_spin[cur_col]) + 3'(dn_spin[cur_col])
                   + 3'(mid_spin[col_l]) + 3'(mid_spin[col_r]);
  assign kk        = signed'({3'b000, nb_up_cnt});
  assign de        = s_old ? (kk <<< 2) - 6'sd8 : 6'sd8 - (kk <<< 2);

  assign pop_addr    = pend_count - CW'(1);
  assign stack_raddr = pop_addr[SAW-1:0];
  assign push_do     = push_mask[push_idx] && (pend_count < CW'(STACK_DEPTH));
  assign pop_hit     = spin_rd[pop_site[RW-1:0]] != seed_spin;
  assign mag_abs     = magnet[MW-1] ? MW'(MW'(0) - magnet) : MW'(magnet);

  always_comb begin
    side_new = SW'(cfg_wdata[icfe_pkg::SIDE_CFG_W-1:0]);
    if (32'(cfg_wdata[icfe_pkg::SIDE_CFG_W-1:0]) < 32'd2) begin
      side_new = SW'(2);
    end else if (32'(cfg_wdata[icfe_pkg::SIDE_CFG_W-1:0]) > 32'(MAX_SIDE)) begin
      side_new = SW'(MAX_SIDE);
    end
    side_sq = (2 * SW)'(side_new) * (2 * SW)'(side_new);
  end

  assign restart = cfg_we && (cfg_addr == icfe_pkg::CFG_SIDE);

  // next state
  always_comb begin
    state_next = state;
    case (state)
      icfe_pkg::ST_WAIT: begin
        if (in_acc) begin
          case (phase)
            icfe_pkg::PH_COL:  state_next = icfe_pkg::ST_RD0;
            icfe_pkg::PH_GROW: state_next = bond_ok ? icfe_pkg::ST_RD0 : icfe_pkg::ST_POP;
            default:           state_next = icfe_pkg::ST_WAIT;
          endcase
        end
      end
      icfe_pkg::ST_RD0:    state_next = icfe_pkg::ST_RD1;
      icfe_pkg::ST_RD1:    state_next = icfe_pkg::ST_RD2;
      icfe_pkg::ST_RD2:    state_next = icfe_pkg::ST_RD3;
      icfe_pkg::ST_RD3:    state_next = icfe_pkg::ST_FLIP;
      icfe_pkg::ST_FLIP:   state_next = icfe_pkg::ST_PUSH;
      icfe_pkg::ST_PUSH:   state_next = (push_idx == 2'd3) ? icfe_pkg::ST_POP : icfe_pkg::ST_PUSH;
      icfe_pkg::ST_POP:    state_next = (pend_count == '0) ? icfe_pkg::ST_EMIT
                                                           : icfe_pkg::ST_POP_RD;
      icfe_pkg::ST_POP_RD: state_next = icfe_pkg::ST_CHK;
      icfe_pkg::ST_CHK:    state_next = pop_hit ? icfe_pkg::ST_WAIT : icfe_pkg::ST_POP;
      icfe_pkg::ST_EMIT:   state_next = (m_tvalid && !m_tready) ? icfe_pkg::ST_EMIT
                                                                : icfe_pkg::ST_WAIT;
      default:             state_next = icfe_pkg::ST_WAIT;
    endcase
  end

  // outputs and memory control
  always_comb begin
    s_tready  = 1'b0;
    rd_row    = cur_row;
    wr_en     = 1'b0;
    clr_marks = 1'b0;
    spin_wr   = mid_spin;
    mark_wr   = mid_mark;
    spin_wr[cur_col] = ~s_old;
    mark_wr[cur_col] = 1'b1;
    case (state)
      icfe_pkg::ST_WAIT:   s_tready = 1'b1;
      icfe_pkg::ST_RD0:    rd_row = row_up;
      icfe_pkg::ST_RD1:    rd_row = cur_row;
      icfe_pkg::ST_RD2:    rd_row = row_dn;
      icfe_pkg::ST_FLIP:   wr_en = 1'b1;
      icfe_pkg::ST_POP_RD: rd_row = stack_q[STW-1:RW];
      icfe_pkg::ST_EMIT:   clr_marks = !(m_tvalid && !m_tready);
      default: ;
    endcase
  end

  icfe_row_store #(.ROWS(MAX_SIDE), .COLS(MAX_SIDE), .FILL(1'b1)) u_spin (
    .clk(clk), .rst(rst), .clr(restart),
    .rd_row(rd_row), .rd_data(spin_rd),
    .wr_en(wr_en), .wr_row(cur_row), .wr_data(spin_wr)
  );

  icfe_row_store #(.ROWS(MAX_SIDE), .COLS(MAX_SIDE), .FILL(1'b0)) u_mark (
    .clk(clk), .rst(rst), .clr(restart || clr_marks),
    .rd_row(rd_row), .rd_data(mark_rd),
    .wr_en(wr_en), .wr_row(cur_row), .wr_data(mark_wr)
  );

  always_ff @(posedge clk) begin
    if (state == icfe_pkg::ST_PUSH && push_do) begin
      stack_mem[pend_count[SAW-1:0]] <= push_site[push_idx];
    end
    stack_q <= stack_mem[stack_raddr];
  end

  // datapath payload
  always_ff @(posedge clk) begin
    case (state)
      icfe_pkg::ST_RD1: begin
        up_spin <= spin_rd;
        up_mark <= mark_rd;
      end
      icfe_pkg::ST_RD2: begin
        mid_spin <= spin_rd;
        mid_mark <= mark_rd;
      end
      icfe_pkg::ST_RD3: begin
        dn_spin <= spin_rd;
        dn_mark <= mark_rd;
      end
      icfe_pkg::ST_FLIP: begin
        if (is_seed) begin
          push_site[0] <= {row_up, cur_col};
          push_site[1] <= {row_dn, cur_col};
          push_site[2] <= {cur_row, col_l};
          push_site[3] <= {cur_row, col_r};
          push_mask    <= {mid_spin[col_r] == s_old, mid_spin[col_l] == s_old,
                           dn_spin[cur_col] == s_old, up_spin[cur_col] == s_old};
        end else begin
          push_site[0] <= {row_dn, cur_col};
          push_site[1] <= {row_up, cur_col};
          push_site[2] <= {cur_row, col_r};
          push_site[3] <= {cur_row, col_l};
          push_mask    <= {!mid_mark[col_l], !mid_mark[col_r],
                           !up_mark[cur_col], !dn_mark[cur_col]};
        end
      end
      icfe_pkg::ST_POP_RD: pop_site <= stack_q;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= icfe_pkg::ST_WAIT;
      phase      <= icfe_pkg::PH_ROW;
      side       <= SW'(SIDE_RST);
      thresh     <= icfe_pkg::THRESH_RESET;
      seed_row   <= '0;
      seed_spin  <= 1'b0;
      held_site  <= '0;
      cur_row    <= '0;
      cur_col    <= '0;
      is_seed    <= 1'b0;
      bond_tries <= icfe_pkg::WORK_W'(1);
      magnet     <= MW'(SIDE_RST * SIDE_RST);
      energy     <= EW'(-2 * SIDE_RST * SIDE_RST);
      pend_count <= '0;
      push_idx   <= '0;
      m_tvalid   <= 1'b0;
    end else if (restart) begin
      state      <= icfe_pkg::ST_WAIT;
      phase      <= icfe_pkg::PH_ROW;
      side       <= side_new;
      seed_row   <= '0;
      seed_spin  <= 1'b0;
      held_site  <= '0;
      bond_tries <= icfe_pkg::WORK_W'(1);
      magnet     <= MW'(side_sq);
      energy     <= EW'(0) - EW'({side_sq, 1'b0});
      pend_count <= '0;
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end else begin
      state <= state_next;
      if (cfg_we && cfg_addr == icfe_pkg::CFG_THRESH) begin
        thresh <= cfg_wdata;
      end
      // in the result state an accepted item is replaced by the new one
      if (m_tvalid && m_tready && state != icfe_pkg::ST_EMIT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        icfe_pkg::ST_WAIT: begin
          if (in_acc) begin
            case (phase)
              icfe_pkg::PH_ROW: begin
                seed_row <= pick;
                phase    <= icfe_pkg::PH_COL;
              end
              icfe_pkg::PH_COL: begin
                cur_row <= seed_row;
                cur_col <= pick;
                is_seed <= 1'b1;
              end
              default: begin
                cur_row <= held_site[STW-1:RW];
                cur_col <= held_site[RW-1:0];
                is_seed <= 1'b0;
              end
            endcase
          end
        end
        icfe_pkg::ST_FLIP: begin
          energy   <= energy + EW'(de);
          magnet   <= s_old ? magnet - MW'(2) : magnet + MW'(2);
          push_idx <= '0;
          if (is_seed) begin
            seed_spin <= ~s_old;
          end
        end
        icfe_pkg::ST_PUSH: begin
          push_idx <= push_idx + 2'd1;
          if (push_do) begin
            pend_count <= pend_count + CW'(1);
          end
        end
        icfe_pkg::ST_POP: begin
          if (pend_count != '0) begin
            pend_count <= pop_addr;
          end
        end
        icfe_pkg::ST_CHK: begin
          if (pop_hit) begin
            held_site <= pop_site;
            phase     <= icfe_pkg::PH_GROW;
            if (bond_tries < icfe_pkg::WORK_W'(icfe_pkg::WORK_MAX)) begin
              bond_tries <= bond_tries + icfe_pkg::WORK_W'(1);
            end
          end
        end
        icfe_pkg::ST_EMIT: begin
          if (!(m_tvalid && !m_tready)) begin
            m_tvalid   <= 1'b1;
            m_tdata    <= {{PAD_W{1'b0}}, energy[icfe_pkg::ENERGY_W-1:0],
                           mag_abs[icfe_pkg::MAG_W-1:0], bond_tries};
            bond_tries <= icfe_pkg::WORK_W'(1);
            phase      <= icfe_pkg::PH_ROW;
          end
        end
        default: ;
      endcase
    end
  end

  a_stack_bound: assert property (@(posedge clk) disable iff (rst)
    pend_count <= CW'(STACK_DEPTH))
    else $error("stack count past depth");

  a_emit_empty: assert property (@(posedge clk) disable iff (rst)
    state == icfe_pkg::ST_EMIT |-> pend_count == '0)
    else $error("result with sites pending");

  a_tries_nonzero: assert property (@(posedge clk) disable iff (rst)
    bond_tries != '0)
    else $error("bond count lost its base of one");

  a_hit_waits: assert property (@(posedge clk) disable iff (rst)
    (state == icfe_pkg::ST_CHK && pop_hit && !restart)
      |=> (state == icfe_pkg::ST_WAIT && phase == icfe_pkg::PH_GROW))
    else $error("tried bond did not wait for a draw");

endmodule

`default_nettype wire

@@ bench/cluster_checker.sv @@
module cluster_checker (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                s_tvalid,
  input  wire logic                                s_tready,
  input  wire logic [icfe_pkg::RAND_W-1:0]         s_tdata,
  input  wire logic                                m_tvalid,
  input  wire logic                                m_tready,
  input  wire logic [icfe_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  wire logic                                cfg_we,
  input  wire logic [icfe_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  wire logic [icfe_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output int                                       errors,
  output int                                       clusters_seen,
  output int                                       clusters_owed,
  output logic                                     at_seed_row
);

  typedef struct {
    logic [icfe_pkg::WORK_W-1:0]   work;
    logic [icfe_pkg::MAG_W-1:0]    mag;
    logic [icfe_pkg::ENERGY_W-1:0] energy;
  } cluster_result_t;

  localparam int SIDE_MAX = icfe_pkg::MAX_SIDE_DEF;
  localparam int SITES = SIDE_MAX * SIDE_MAX;

  cluster_result_t expected_clusters[$];
  int   walk_stack[$];
  bit   spin_up[SITES];
  bit   in_cluster[SITES];
  int   side;
  logic [31:0] thresh;
  icfe_pkg::phase_t walk_phase;
  int   seed_row_q;
  bit   seed_spin_q;
  int   held;
  int   tries;
  int   magnet;
  int   energy_sum;

  function automatic int site_at(int r, int c);
    return r * SIDE_MAX + c;
  endfunction

  function automatic int spin_sign(int site);
    return spin_up[site] ? 1 : -1;
  endfunction

  task automatic restart_lattice();
    for (int i = 0; i < SITES; i++) begin
      spin_up[i] = 1'b1;
      in_cluster[i] = 1'b0;
    end
    walk_stack.delete();
    walk_phase = icfe_pkg::PH_ROW;
    seed_row_q = 0;
    seed_spin_q = 1'b0;
    held = 0;
    tries = 1;
    magnet = side * side;
    energy_sum = -2 * side * side;
  endtask

  task automatic push_site(int site);
    if (walk_stack.size() < icfe_pkg::STACK_DEPTH_DEF) walk_stack.push_back(site);
  endtask

  task automatic flip_site(int site);
    int r, c, s, ns;
    r = (site / SIDE_MAX) % side;
    c = (site % SIDE_MAX) % side;
    s = spin_sign(site);
    ns = spin_sign(site_at((r + side - 1) % side, c)) + spin_sign(site_at((r + 1) % side, c))
       + spin_sign(site_at(r, (c + side - 1) % side)) + spin_sign(site_at(r, (c + 1) % side));
    energy_sum += 2 * s * ns;
    magnet -= 2 * s;
    spin_up[site] = ~spin_up[site];
    in_cluster[site] = 1'b1;
  endtask

  task automatic walk_stack_down();
    cluster_result_t res;
    int site, m;
    while (walk_stack.size() > 0) begin
      site = walk_stack.pop_back();
      if (spin_up[site] != seed_spin_q) begin
        held = site;
        if (tries < icfe_pkg::WORK_MAX) tries++;
        walk_phase = icfe_pkg::PH_GROW;
        return;
      end
    end
    m = magnet < 0 ? -magnet : magnet;
    res.work = tries[icfe_pkg::WORK_W-1:0];
    res.mag = m[icfe_pkg::MAG_W-1:0];
    res.energy = energy_sum[icfe_pkg::ENERGY_W-1:0];
    expected_clusters.push_back(res);
    for (int i = 0; i < SITES; i++) in_cluster[i] = 1'b0;
    tries = 1;
    walk_phase = icfe_pkg::PH_ROW;
  endtask

  task automatic take_draw(logic [31:0] u);
    int pick, r, c, seed;
    int nb[4];
    logic [63:0] prod;
    prod = 64'(side) * 64'(u);
    pick = int'(prod[63:32]);
    case (walk_phase)
      icfe_pkg::PH_COL: begin
        r = seed_row_q % side;
        c = pick % side;
        seed = site_at(r, c);
        flip_site(seed);
        seed_spin_q = spin_up[seed];
        tries = 1;
        walk_stack.delete();
        nb[0] = site_at((r + side - 1) % side, c);
        nb[1] = site_at((r + 1) % side, c);
        nb[2] = site_at(r, (c + side - 1) % side);
        nb[3] = site_at(r, (c + 1) % side);
        foreach (nb[k]) if (spin_up[nb[k]] != seed_spin_q) push_site(nb[k]);
        walk_stack_down();
      end
      icfe_pkg::PH_GROW: begin
        if (u < thresh) begin
          r = (held / SIDE_MAX) % side;
          c = (held % SIDE_MAX) % side;
          flip_site(held);
          nb[0] = site_at((r + 1) % side, c);
          nb[1] = site_at((r + side - 1) % side, c);
          nb[2] = site_at(r, (c + 1) % side);
          nb[3] = site_at(r, (c + side - 1) % side);
          foreach (nb[k]) if (!in_cluster[nb[k]]) push_site(nb[k]);
        end
        walk_stack_down();
      end
      default: begin
        seed_row_q = pick % side;
        walk_phase = icfe_pkg::PH_COL;
      end
    endcase
  endtask

  task automatic report(string what, int got, int want);
    $display("cluster %0d: %s got %0d expected %0d", clusters_seen, what, got, want);
    errors = errors + 1;
  endtask

  always @(posedge clk) begin
    cluster_result_t want;
    int v;
    if (rst) begin
      side = icfe_pkg::SIDE_RESET;
      thresh = icfe_pkg::THRESH_RESET;
      restart_lattice();
      expected_clusters.delete();
      errors = 0;
      clusters_seen <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        clusters_seen <= clusters_seen + 1;
        if (expected_clusters.size() == 0) begin
          report("unexpected item", int'(m_tdata[14:0]), 0);
        end else begin
          want = expected_clusters.pop_front();
          if (m_tdata[14:0] !== want.work)
            report("cluster_work", int'(m_tdata[14:0]), int'(want.work));
          if (m_tdata[27:15] !== want.mag)
            report("magnetization_abs", int'(m_tdata[27:15]), int'(want.mag));
          if (m_tdata[42:28] !== want.energy)
            report("total_energy", int'(m_tdata[42:28]), int'(want.energy));
        end
      end
      if (cfg_we) begin
        if (icfe_pkg::cfg_reg_t'(cfg_addr) == icfe_pkg::CFG_SIDE) begin
          v = int'(cfg_wdata[6:0]);
          side = v < 2 ? 2 : (v > SIDE_MAX ? SIDE_MAX : v);
          restart_lattice();
        end else begin
          thresh = cfg_wdata;
        end
      end
      if (s_tvalid && s_tready) take_draw(s_tdata);
    end
    clusters_owed <= expected_clusters.size();
    at_seed_row <= (walk_phase == icfe_pkg::PH_ROW);
  end
endmodule

@@ bench/tb_top.sv @@
module tb_top;

  localparam int CYCLE_LIMIT = 6000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [icfe_pkg::RAND_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [icfe_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic cfg_we = 1'b0;
  logic [icfe_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [icfe_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  int errors, clusters_seen, clusters_owed;
  logic at_seed_row;
  int cycles = 0;
  int burst_left = 0;
  int ready_pct = 100;
  int draws_sent = 0;

  always #4 clk = ~clk;

  ising_cluster_flip_engine_unit DUT (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_addr, .cfg_wdata
  );

  cluster_checker u_checker (
    .clk, .rst, .s_tvalid, .s_tready, .s_tdata,
    .m_tvalid, .m_tready, .m_tdata, .cfg_we, .cfg_addr, .cfg_wdata,
    .errors, .clusters_seen, .clusters_owed, .at_seed_row
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 64 == 0) ready_pct <= ($urandom_range(0, 2) == 0) ? 100 : $urandom_range(20, 90);
    m_tready <= ($urandom_range(0, 99) < ready_pct);
    if (cycles > CYCLE_LIMIT) begin
      $display("ising_cluster_flip_engine_unit: mismatch");
      $finish;
    end
  end

  // the task itself lowers tvalid after the last item of a stretch
  task automatic send_draw(logic [31:0] u);
    s_tdata <= u;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    draws_sent++;
    if (burst_left == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 30);
    end else begin
      burst_left--;
    end
  endtask

  // the top draw is never below the threshold, so the walk drains quickly
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (!at_seed_row) begin
      burst_left = 0;
      send_draw(32'hFFFF_FFFF);
    end
    while (clusters_owed != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(icfe_pkg::cfg_reg_t idx, logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_threshold();
    case ($urandom_range(0, 5))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return icfe_pkg::THRESH_RESET;
      default: return $urandom();
    endcase
  endfunction

  initial begin
    int side;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset config: corner seeds, draws at both extremes
    send_draw(32'h0);
    send_draw(32'hFFFF_FFFF);
    send_draw(32'hFFFF_FFFF);
    send_draw(32'h0);
    send_draw(32'h9600_0000);
    settle();

    // side below range acts as 2; full threshold, top draw rejected
    write_reg(icfe_pkg::CFG_SIDE, 32'd0);
    write_reg(icfe_pkg::CFG_THRESH, 32'hFFFF_FFFF);
    send_draw(32'hFFFF_FFFF);
    send_draw(32'h0);
    send_draw(32'hFFFF_FFFF);
    send_draw(32'h0);
    settle();
    write_reg(icfe_pkg::CFG_SIDE, 32'd1);
    write_reg(icfe_pkg::CFG_THRESH, 32'h0);
    repeat (6) send_draw($urandom());
    settle();
    write_reg(icfe_pkg::CFG_SIDE, 32'd127);
    write_reg(icfe_pkg::CFG_THRESH, 32'h1);
    send_draw(32'h8000_0000);
    send_draw(32'h8000_0000);
    send_draw(32'h0);
    settle();
    write_reg(icfe_pkg::CFG_SIDE, 32'd65);
    write_reg(icfe_pkg::CFG_THRESH, 32'h0);
    repeat (4) send_draw($urandom());
    settle();

    while (draws_sent < 680) begin
      side = $urandom_range(0, 9) == 0 ? $urandom_range(2, 64) : $urandom_range(2, 10);
      write_reg(icfe_pkg::CFG_SIDE, 32'(side));
      write_reg(icfe_pkg::CFG_THRESH, pick_threshold());
      repeat ($urandom_range(20, 80)) send_draw($urandom());
      settle();
    end

    if (errors == 0) begin
      $display("ising_cluster_flip_engine_unit: match");
    end else begin
      $display("ising_cluster_flip_engine_unit: mismatch");
    end
    $finish;
  end
endmodule
